FILE: sv/canfd_tx_element_encoder_assert.svh
// ----------------------------------------------------------------------------
// CAN FD transmit element encoder - assertion macros
// Shorthand for concurrent assertions clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef CANFD_TX_ELEMENT_ENCODER_ASSERT_SVH
`define CANFD_TX_ELEMENT_ENCODER_ASSERT_SVH

// Assertion that is switched off while reset is asserted.
`define CTE_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("encoder port check failed");

// Assertion that is checked at every clock edge, reset included.
`define CTE_ASSERT_ALL(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("encoder reset check failed");

`endif

FILE: sv/cte_pkg.sv
// ----------------------------------------------------------------------------
// CAN FD transmit element encoder - package
// Shared constants, types and small formatting functions.
// ----------------------------------------------------------------------------
`default_nettype none

package cte_pkg;

  // Message RAM and slot geometry.
  localparam int RAM_WORDS  = 4096;
  localparam int ADDR_W     = $clog2(RAM_WORDS);
  localparam int SLOT_COUNT = 32;
  localparam int SLOT_W     = 5;
  localparam int ID_W       = 29;
  localparam int LEN_W      = 7;
  localparam int CNT_W      = 5;

  // Configuration register indexes.
  localparam logic CFG_SLOT_CODE = 1'b0;
  localparam logic CFG_TX_BASE   = 1'b1;

  // Item kinds.
  typedef enum logic {
    REQ_HEADER = 1'b0,
    REQ_DATA   = 1'b1
  } req_type_t;

  // Frame kinds.
  typedef enum logic [1:0] {
    KIND_CLASSIC = 2'd0,
    KIND_REMOTE  = 2'd1,
    KIND_FD      = 2'd2,
    KIND_FD_BRS  = 2'd3
  } frame_kind_t;

  // One word headed for message RAM.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
    logic              last;
    logic [SLOT_W-1:0] slot;
  } out_word_t;

  // Formatted header: both element words plus the element bookkeeping.
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [31:0]       w0;
    logic [31:0]       w1;
    logic [CNT_W-1:0]  expect_words;
    logic              last;
  } hdr_t;

  // Data bytes per slot for each size code.
  function automatic logic [LEN_W-1:0] slot_bytes(input logic [2:0] code);
    logic [LEN_W-1:0] b;
    case (code)
      3'd0:    b = 7'd8;
      3'd1:    b = 7'd12;
      3'd2:    b = 7'd16;
      3'd3:    b = 7'd20;
      3'd4:    b = 7'd24;
      3'd5:    b = 7'd32;
      3'd6:    b = 7'd48;
      default: b = 7'd64;
    endcase
    return b;
  endfunction

  // FD data length code from a byte count.
  function automatic logic [3:0] dlc_of(input logic [LEN_W-1:0] len);
    logic [3:0] d;
    if (len > 7'd48)      d = 4'd15;
    else if (len > 7'd32) d = 4'd14;
    else if (len > 7'd24) d = 4'd13;
    else if (len > 7'd20) d = 4'd12;
    else if (len > 7'd16) d = 4'd11;
    else if (len > 7'd12) d = 4'd10;
    else if (len > 7'd8)  d = 4'd9;
    else                  d = len[3:0];
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: sv/canfd_tx_element_encoder.sv
// ----------------------------------------------------------------------------
// CAN FD transmit element encoder - top level
// Turns header and payload words into message RAM writes of a transmit
// buffer element and flags the final write with a transmission request.
// ----------------------------------------------------------------------------
// A word is taken into an input register and then formatted and written into
// a four-word output queue that feeds the message RAM writes. The single RAM
// write port sets the pace: a payload word makes one RAM write and a header
// makes two, since it writes the identifier word and the length-code word on
// consecutive beats. Input words keep flowing while the RAM side stalls until
// the queue has fewer than two free entries.
// ----------------------------------------------------------------------------
`default_nettype none

module canfd_tx_element_encoder (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Configuration write port.
  input  wire logic                         cfg_write_en,
  input  wire logic                         cfg_index,
  input  wire logic [11:0]                  cfg_data,
  // Input channel.
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_req_type,
  input  wire logic [4:0]                   in_buffer_index,
  input  wire logic                         in_extended_id,
  input  wire logic [28:0]                  in_identifier,
  input  wire logic [6:0]                   in_byte_length,
  input  wire logic [1:0]                   in_frame_kind,
  input  wire logic [31:0]                  in_payload_word,
  // Result channel.
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [11:0]                       out_ram_address,
  output logic [31:0]                       out_ram_data,
  output logic                              out_last_write,
  output logic                              out_send_request,
  output logic [4:0]                        out_request_slot
);

  // Configuration registers.
  logic [2:0]                     slot_code_r;
  logic [cte_pkg::ADDR_W-1:0]     tx_base_r;

  // Input register.
  logic                           s1_valid_r, s1_valid_nxt;
  logic                           s1_req_r;
  logic [cte_pkg::SLOT_W-1:0]     s1_slot_r;
  logic                           s1_ext_r;
  logic [cte_pkg::ID_W-1:0]       s1_id_r;
  logic [cte_pkg::LEN_W-1:0]      s1_len_r;
  logic [1:0]                     s1_kind_r;
  logic [31:0]                    s1_payload_r;

  // Element tracking state.
  logic                           active_r, active_nxt;
  logic [cte_pkg::ADDR_W-1:0]     elem_base_r, elem_base_nxt;
  logic [cte_pkg::CNT_W-1:0]      expect_r, expect_nxt;
  logic [cte_pkg::CNT_W-1:0]      written_r, written_nxt;
  logic [cte_pkg::SLOT_W-1:0]     slot_r, slot_nxt;

  logic                           in_accept;
  logic                           s1_adv;
  logic                           room2;
  logic                           not_empty;
  logic                           slot_ok;
  logic [cte_pkg::CNT_W-1:0]      written_inc;
  logic                           data_last;
  logic [1:0]                     push_cnt;
  cte_pkg::hdr_t                  hdr;
  cte_pkg::out_word_t             push0;
  cte_pkg::out_word_t             push1;
  cte_pkg::out_word_t             head;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_code_r <= 3'd0;
      tx_base_r   <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        cte_pkg::CFG_SLOT_CODE: slot_code_r <= cfg_data[2:0];
        cte_pkg::CFG_TX_BASE:   tx_base_r   <= cfg_data[cte_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake: the input register moves on when the queue has room.
  assign s1_adv    = s1_valid_r && room2;
  assign in_stall  = s1_valid_r && !room2;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r     <= in_req_type;
      s1_slot_r    <= in_buffer_index;
      s1_ext_r     <= in_extended_id;
      s1_id_r      <= in_identifier;
      s1_len_r     <= in_byte_length;
      s1_kind_r    <= in_frame_kind;
      s1_payload_r <= in_payload_word;
    end
  end

  // Header formatting.
  cte_hdr_fmt u_hdr_fmt (
    .slot_code (slot_code_r),
    .tx_base   (tx_base_r),
    .slot      (s1_slot_r),
    .ext       (s1_ext_r),
    .id        (s1_id_r),
    .len       (s1_len_r),
    .kind      (s1_kind_r),
    .hdr       (hdr)
  );

  assign slot_ok     = ({1'b0, s1_slot_r} < 6'(cte_pkg::SLOT_COUNT));
  assign written_inc = written_r + 5'd1;
  assign data_last   = (written_inc >= expect_r);

  // Words to queue and element state update for the registered word.
  always_comb begin
    push_cnt      = 2'd0;
    push0         = '0;
    push1         = '0;
    active_nxt    = active_r;
    elem_base_nxt = elem_base_r;
    expect_nxt    = expect_r;
    written_nxt   = written_r;
    slot_nxt      = slot_r;
    if (s1_adv) begin
      case (cte_pkg::req_type_t'(s1_req_r))
        cte_pkg::REQ_HEADER: begin
          if (slot_ok) begin
            push_cnt      = 2'd2;
            push0.addr    = hdr.base;
            push0.data    = hdr.w0;
            push1.addr    = hdr.base + cte_pkg::ADDR_W'(1);
            push1.data    = hdr.w1;
            push1.last    = hdr.last;
            push1.slot    = hdr.last ? s1_slot_r : '0;
            active_nxt    = !hdr.last;
            elem_base_nxt = hdr.base;
            expect_nxt    = hdr.expect_words;
            written_nxt   = 5'd0;
            slot_nxt      = s1_slot_r;
          end
        end
        cte_pkg::REQ_DATA: begin
          if (active_r) begin
            push_cnt    = 2'd1;
            push0.addr  = elem_base_r + cte_pkg::ADDR_W'(2) + cte_pkg::ADDR_W'(written_r);
            push0.data  = s1_payload_r;
            push0.last  = data_last;
            push0.slot  = data_last ? slot_r : '0;
            written_nxt = written_inc;
            if (data_last) begin
              active_nxt = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      elem_base_r <= '0;
      expect_r    <= '0;
      written_r   <= '0;
      slot_r      <= '0;
    end else begin
      active_r    <= active_nxt;
      elem_base_r <= elem_base_nxt;
      expect_r    <= expect_nxt;
      written_r   <= written_nxt;
      slot_r      <= slot_nxt;
    end
  end

  // Output queue toward message RAM.
  cte_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (push0),
    .push1     (push1),
    .pop       (!out_stall),
    .not_empty (not_empty),
    .room2     (room2),
    .head      (head)
  );

  assign out_valid        = not_empty;
  assign out_ram_address  = head.addr;
  assign out_ram_data     = head.data;
  assign out_last_write   = head.last;
  assign out_send_request = head.last;
  assign out_request_slot = head.slot;

endmodule

`default_nettype wire

FILE: sv/cte_hdr_fmt.sv
// ----------------------------------------------------------------------------
// CAN FD transmit element encoder - header formatter
// Builds the identifier word, the length-code word, the element address and
// the expected payload word count from one header word.
// ----------------------------------------------------------------------------
`default_nettype none

module cte_hdr_fmt (
  input  wire logic [2:0]                    slot_code,
  input  wire logic [cte_pkg::ADDR_W-1:0]    tx_base,
  input  wire logic [cte_pkg::SLOT_W-1:0]    slot,
  input  wire logic                          ext,
  input  wire logic [cte_pkg::ID_W-1:0]      id,
  input  wire logic [cte_pkg::LEN_W-1:0]     len,
  input  wire logic [1:0]                    kind,
  output cte_pkg::hdr_t                      hdr
);

  logic [cte_pkg::LEN_W-1:0] sbytes;
  logic [4:0]                elem_words;
  logic [9:0]                slot_offset;
  logic [cte_pkg::LEN_W-1:0] sent;
  logic [cte_pkg::LEN_W-1:0] sent_up;
  logic [31:0]               w0;
  logic [31:0]               w1;
  logic [cte_pkg::CNT_W-1:0] expect_words;

  // Element geometry: two header words plus the slot's data words.
  always_comb begin
    sbytes      = cte_pkg::slot_bytes(slot_code);
    elem_words  = 5'd2 + 5'(sbytes >> 2);
    slot_offset = 10'(slot) * 10'(elem_words);
    sent        = (sbytes < len) ? sbytes : len;
    sent_up     = sent + 7'd3;
  end

  // Identifier word, length-code word and payload count per frame kind.
  always_comb begin
    if (ext) begin
      w0 = {2'b01, 1'b0, id};
    end else begin
      w0 = {3'b000, id[10:0], 18'd0};
    end
    w1 = {10'd0, 1'b0, 1'b0, cte_pkg::dlc_of(len), 16'd0};
    case (cte_pkg::frame_kind_t'(kind))
      cte_pkg::KIND_CLASSIC: begin
        expect_words = 5'd2;
      end
      cte_pkg::KIND_REMOTE: begin
        w0[29]       = 1'b1;
        expect_words = 5'd0;
      end
      cte_pkg::KIND_FD: begin
        w1[21]       = 1'b1;
        expect_words = 5'(sent_up >> 2);
      end
      cte_pkg::KIND_FD_BRS: begin
        w1[21]       = 1'b1;
        w1[20]       = 1'b1;
        expect_words = 5'(sent_up >> 2);
      end
      default: begin
        expect_words = 5'd0;
      end
    endcase
  end

  // Pack the result; the address wraps at the message RAM size.
  always_comb begin
    hdr.base         = tx_base + cte_pkg::ADDR_W'(slot_offset);
    hdr.w0           = w0;
    hdr.w1           = w1;
    hdr.expect_words = expect_words;
    hdr.last         = (expect_words == 5'd0);
  end

endmodule

`default_nettype wire

FILE: sv/cte_out_fifo.sv
// ----------------------------------------------------------------------------
// CAN FD transmit element encoder - output queue
// Four-word queue that takes up to two words a cycle and hands out one while pop is held.
// ----------------------------------------------------------------------------
`default_nettype none

module cte_out_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [1:0]         push_cnt,
  input  wire cte_pkg::out_word_t push0,
  input  wire cte_pkg::out_word_t push1,
  input  wire logic               pop,
  output logic                    not_empty,
  output logic                    room2,
  output cte_pkg::out_word_t      head
);

  cte_pkg::out_word_t mem_r [4];
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       do_pop;

  assign not_empty = (count_r != 3'd0);
  assign room2     = (count_r <= 3'd2);
  assign head      = mem_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  // Pointer and fill count update.
  always_comb begin
    rd_ptr_nxt = rd_ptr_r + 2'(do_pop);
    wr_ptr_nxt = wr_ptr_r + push_cnt;
    count_nxt  = count_r + 3'(push_cnt) - 3'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 2'd0;
      wr_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Word storage; the caller pushes only when two entries are free.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= push1;
    end
  end

endmodule

`default_nettype wire

FILE: sv/cte_checker.sv
// ----------------------------------------------------------------------------
// CAN FD transmit element encoder - port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "canfd_tx_element_encoder_assert.svh"

module cte_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [11:0] out_ram_address,
  input wire logic [31:0] out_ram_data,
  input wire logic        out_last_write,
  input wire logic        out_send_request,
  input wire logic [4:0]  out_request_slot
);

  // A request goes out exactly with the final word of an element.
  `CTE_ASSERT_RST(a_req_with_last, clk, rst_n, out_valid |-> (out_send_request == out_last_write))

  // The slot field is clear on every word that carries no request.
  `CTE_ASSERT_RST(a_slot_clear, clk, rst_n, (out_valid && !out_send_request) |-> (out_request_slot == 5'd0))

  // A stalled word holds its address and data.
  `CTE_ASSERT_RST(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_ram_address) && $stable(out_ram_data)))

  // Right after reset nothing is offered on the RAM side and the input is not stalled.
  `CTE_ASSERT_ALL(a_reset_empty, clk, (!rst_n) |=> (!out_valid && !in_stall))

endmodule

bind canfd_tx_element_encoder cte_checker u_cte_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_ram_address  (out_ram_address),
  .out_ram_data     (out_ram_data),
  .out_last_write   (out_last_write),
  .out_send_request (out_send_request),
  .out_request_slot (out_request_slot)
);

`default_nettype wire
